@@ hdl/ccadv_pkg.sv @@
// ============================================================================
// ccadv_pkg: shared types, constants and functions of the calendar clock
// Holds the word formats of both channels, the control structs between the
// sequencer, the shared divider and the calendar registers, and the
// Gregorian month length function.
// ============================================================================
package ccadv_pkg;

    localparam int SEC_WIDTH      = 6;
    localparam int MIN_WIDTH      = 6;
    localparam int HOUR_WIDTH     = 5;
    localparam int DAY_WIDTH      = 5;
    localparam int MONTH_WIDTH    = 4;
    localparam int YEAR_WIDTH     = 16;
    localparam int AMOUNT_WIDTH   = 24;

    // The first dividend is second plus amount, one bit wider than amount.
    localparam int DIV_WIDTH      = AMOUNT_WIDTH + 1;
    localparam int DIVISOR_WIDTH  = 6;
    // Whole days left over from the largest advance stay below 256.
    localparam int DAYS_WIDTH     = 8;

    localparam logic [DIVISOR_WIDTH-1:0] SECS_PER_MIN   = 6'd60;
    localparam logic [DIVISOR_WIDTH-1:0] MINS_PER_HOUR  = 6'd60;
    localparam logic [DIVISOR_WIDTH-1:0] HOURS_PER_DAY  = 6'd24;
    localparam logic [MONTH_WIDTH-1:0]   MONTHS_PER_YEAR = 4'd12;
    localparam logic [MONTH_WIDTH-1:0]   MONTH_FEB       = 4'd2;

    // Reciprocals rounded up, scaled by 2**RECIP_SHIFT. For any dividend
    // below 2**DIV_WIDTH the rounding error stays under one quotient step.
    localparam int RECIP_WIDTH    = 27;
    localparam int RECIP_SHIFT    = 31;
    localparam logic [RECIP_WIDTH-1:0] RECIP_60 = 27'd35791395;
    localparam logic [RECIP_WIDTH-1:0] RECIP_24 = 27'd89478486;

    // Multiplicative inverse of 25 modulo 2**16 and the largest product
    // that marks a multiple of 25.
    localparam logic [YEAR_WIDTH-1:0] INV_25       = 16'd23593;
    localparam logic [YEAR_WIDTH-1:0] MULT_25_MAX  = 16'd2621;

    localparam logic [DAY_WIDTH-1:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic {
        ACT_ADVANCE = 1'b0,
        ACT_LOAD    = 1'b1
    } action_t;

    typedef struct packed {
        action_t                  action;
        logic [AMOUNT_WIDTH-1:0]  amount;
        logic [SEC_WIDTH-1:0]     load_second;
        logic [MIN_WIDTH-1:0]     load_minute;
        logic [HOUR_WIDTH-1:0]    load_hour;
        logic [DAY_WIDTH-1:0]     load_day;
        logic [MONTH_WIDTH-1:0]   load_month;
        logic [YEAR_WIDTH-1:0]    load_year;
    } cmd_word_t;

    typedef struct packed {
        logic [SEC_WIDTH-1:0]     cur_second;
        logic [MIN_WIDTH-1:0]     cur_minute;
        logic [HOUR_WIDTH-1:0]    cur_hour;
        logic [DAY_WIDTH-1:0]     cur_day;
        logic [MONTH_WIDTH-1:0]   cur_month;
        logic [YEAR_WIDTH-1:0]    cur_year;
        logic                     load_error;
    } rsp_word_t;

    typedef struct packed {
        logic                     start;
        logic [DIV_WIDTH-1:0]     dividend;
        logic [DIVISOR_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic [DIV_WIDTH-1:0]     quotient;
        logic [DIVISOR_WIDTH-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [DAY_WIDTH-1:0]     day;
        logic [MONTH_WIDTH-1:0]   month;
        logic [YEAR_WIDTH-1:0]    year;
    } cal_date_t;

    typedef struct packed {
        logic                     load;
        logic                     step;
        cal_date_t                date;
    } cal_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_DAYS,
        ST_FINISH
    } seq_state_t;

    // Gregorian rule: divisible by 4 and not by 100, or divisible by 400.
    // With 4 | y, 100 | y is 25 | y, and 400 | y is 16 | y plus 25 | y.
    function automatic logic is_leap(input logic [YEAR_WIDTH-1:0] year);
        logic [YEAR_WIDTH-1:0] prod;
        logic                  mult_25;
        prod    = YEAR_WIDTH'(year * INV_25);
        mult_25 = (prod <= MULT_25_MAX);
        return (year[1:0] == 2'd0) && (!mult_25 || (year[3:0] == 4'd0));
    endfunction

    function automatic logic [DAY_WIDTH-1:0] days_in(
        input logic [MONTH_WIDTH-1:0] month,
        input logic [YEAR_WIDTH-1:0]  year
    );
        logic [MONTH_WIDTH-1:0] idx;
        logic [DAY_WIDTH-1:0]   len;
        idx = (month >= 4'd1 && month <= MONTHS_PER_YEAR) ? month - 4'd1 : 4'd0;
        len = MONTH_DAYS[idx];
        if (month == MONTH_FEB && is_leap(year))
        begin
            len = 5'd29;
        end
        return len;
    endfunction

endpackage

@@ hdl/ccadv_div.sv @@
// ============================================================================
// ccadv_div: shared reciprocal divider
// Divides a word by 60 or 24 through multiplication by a scaled reciprocal,
// registering the operands, then the product, then quotient and remainder,
// and reports quotient and remainder with a one-cycle done pulse.
// ============================================================================
module ccadv_div (
    input  logic                clk,
    input  logic                rst_n,
    input  ccadv_pkg::div_req_t req,
    output ccadv_pkg::div_rsp_t rsp
);
    import ccadv_pkg::*;

    localparam int ProdWidth = DIV_WIDTH + RECIP_WIDTH;

    logic                     mul_pend_reg, mul_pend_next;
    logic                     fin_pend_reg, fin_pend_next;
    logic                     done_reg, done_next;
    logic [DIV_WIDTH-1:0]     num_reg, num_next;
    logic [RECIP_WIDTH-1:0]   recip_reg, recip_next;
    logic [DIVISOR_WIDTH-1:0] divisor_reg, divisor_next;
    logic [ProdWidth-1:0]     prod_reg, prod_next;
    logic [DIV_WIDTH-1:0]     quo_reg, quo_next;
    logic [DIVISOR_WIDTH-1:0] rem_reg, rem_next;
    logic [DIV_WIDTH-1:0]     quo_est;
    logic [DIVISOR_WIDTH-1:0] quo_times_div;

    always_comb
    begin
        mul_pend_next = 1'b0;
        fin_pend_next = mul_pend_reg;
        done_next     = fin_pend_reg;
        num_next      = num_reg;
        recip_next    = recip_reg;
        divisor_next  = divisor_reg;
        prod_next     = prod_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;

        quo_est       = DIV_WIDTH'(prod_reg[ProdWidth-1:RECIP_SHIFT]);
        // The remainder is below 64, so the low bits of the product suffice.
        quo_times_div = quo_est[DIVISOR_WIDTH-1:0] * divisor_reg;

        if (req.start)
        begin
            mul_pend_next = 1'b1;
            num_next      = req.dividend;
            divisor_next  = req.divisor;
            recip_next    = (req.divisor == HOURS_PER_DAY) ? RECIP_24 : RECIP_60;
        end

        if (mul_pend_reg)
        begin
            prod_next = ProdWidth'(num_reg) * ProdWidth'(recip_reg);
        end

        if (fin_pend_reg)
        begin
            quo_next = quo_est;
            rem_next = num_reg[DIVISOR_WIDTH-1:0] - quo_times_div;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            fin_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            mul_pend_reg <= mul_pend_next;
            fin_pend_reg <= fin_pend_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        recip_reg   <= recip_next;
        divisor_reg <= divisor_next;
        prod_reg    <= prod_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ hdl/ccadv_cal.sv @@
// ============================================================================
// ccadv_cal: day, month and year registers
// Loads a checked date or moves it forward by one day, with Gregorian month
// lengths, the month wrap after December and the year wrap at its maximum.
// ============================================================================
module ccadv_cal (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccadv_pkg::cal_cmd_t  cmd,
    output ccadv_pkg::cal_date_t date
);
    import ccadv_pkg::*;

    cal_date_t date_reg, date_next;

    always_comb
    begin
        date_next = date_reg;
        if (cmd.load)
        begin
            date_next = cmd.date;
        end
        else if (cmd.step)
        begin
            if (date_reg.day >= days_in(date_reg.month, date_reg.year))
            begin
                date_next.day = 5'd1;
                if (date_reg.month >= MONTHS_PER_YEAR)
                begin
                    date_next.month = 4'd1;
                    date_next.year  = date_reg.year + 1'b1;
                end
                else
                begin
                    date_next.month = date_reg.month + 1'b1;
                end
            end
            else
            begin
                date_next.day = date_reg.day + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.day   <= 5'd1;
            date_reg.month <= 4'd1;
            date_reg.year  <= '0;
        end
        else
        begin
            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

@@ hdl/calendar_clock_advance_unit.sv @@
// Sequence: a load goes to ST_FINISH, where its result word is registered once
// the output register is free; an advance makes three passes through the
// shared divider and one calendar step per whole day carried (at most 195).
// Throughput: one word at a time; the next word is taken once the result is
// in the output register, so a stalled result holds off the next result.
// Reset (rst_n low, asynchronous) sets 00:00:00 on day 1, month 1, year 0.
// ============================================================================
// calendar_clock_advance_unit: Gregorian calendar clock
// Keeps second, minute, hour, day, month and year. A command word either
// loads a checked date and time or advances the clock by a count of
// seconds; each command returns one word with the resulting date and time.
// ============================================================================
module calendar_clock_advance_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  ccadv_pkg::cmd_word_t  cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ccadv_pkg::rsp_word_t  rsp
);
    import ccadv_pkg::*;

    // Sequencer state and the time of day. The calendar part lives in
    // ccadv_cal; the three carry divisions share one divider.
    seq_state_t              state_reg, state_next;
    logic [SEC_WIDTH-1:0]    sec_reg, sec_next;
    logic [MIN_WIDTH-1:0]    min_reg, min_next;
    logic [HOUR_WIDTH-1:0]   hour_reg, hour_next;
    logic [DAYS_WIDTH-1:0]   days_reg, days_next;
    logic                    err_reg, err_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_word_t               rsp_reg, rsp_next;

    div_req_t                div_req;
    div_rsp_t                div_rsp;
    cal_cmd_t                cal_cmd;
    cal_date_t               cal_date;

    logic                    accept;
    logic                    load_ok;
    logic                    out_free;

    ccadv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ccadv_cal u_cal (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cal_cmd),
        .date  (cal_date)
    );

    // The block takes a new word only between items. A finished result may
    // still sit in the output register while the next item is taken.
    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    // A load is checked in full before anything is written: every field in
    // range and the day within the length of that month in that year.
    assign load_ok = (cmd.load_second < SEC_WIDTH'(SECS_PER_MIN))
                  && (cmd.load_minute < MIN_WIDTH'(MINS_PER_HOUR))
                  && (cmd.load_hour < HOUR_WIDTH'(HOURS_PER_DAY))
                  && (cmd.load_month >= 4'd1)
                  && (cmd.load_month <= MONTHS_PER_YEAR)
                  && (cmd.load_day >= 5'd1)
                  && (cmd.load_day <= days_in(cmd.load_month, cmd.load_year));

    // The output register can take a word when empty or when it is being
    // emptied in this cycle.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next       = state_reg;
        sec_next         = sec_reg;
        min_next         = min_reg;
        hour_next        = hour_reg;
        days_next        = days_reg;
        err_next         = err_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;

        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = SECS_PER_MIN;

        cal_cmd.load       = 1'b0;
        cal_cmd.step       = 1'b0;
        cal_cmd.date.day   = cmd.load_day;
        cal_cmd.date.month = cmd.load_month;
        cal_cmd.date.year  = cmd.load_year;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_LOAD)
                    begin
                        // A rejected load leaves the time as it is.
                        err_next = !load_ok;
                        if (load_ok)
                        begin
                            sec_next     = cmd.load_second;
                            min_next     = cmd.load_minute;
                            hour_next    = cmd.load_hour;
                            cal_cmd.load = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // Seconds plus amount, split into minutes carried
                        // and the new second.
                        err_next         = 1'b0;
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_WIDTH'(cmd.amount)
                                         + DIV_WIDTH'(sec_reg);
                        div_req.divisor  = SECS_PER_MIN;
                        state_next       = ST_SEC;
                    end
                end
            end

            ST_SEC:
            begin
                if (div_rsp.done)
                begin
                    sec_next         = div_rsp.remainder;
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient + DIV_WIDTH'(min_reg);
                    div_req.divisor  = MINS_PER_HOUR;
                    state_next       = ST_MIN;
                end
            end

            ST_MIN:
            begin
                if (div_rsp.done)
                begin
                    min_next         = div_rsp.remainder;
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient + DIV_WIDTH'(hour_reg);
                    div_req.divisor  = HOURS_PER_DAY;
                    state_next       = ST_HOUR;
                end
            end

            ST_HOUR:
            begin
                if (div_rsp.done)
                begin
                    // Whole days carried never exceed the day counter's range.
                    hour_next  = div_rsp.remainder[HOUR_WIDTH-1:0];
                    days_next  = div_rsp.quotient[DAYS_WIDTH-1:0];
                    state_next = ST_DAYS;
                end
            end

            ST_DAYS:
            begin
                // One calendar day per cycle, so month lengths and the year
                // roll over exactly as a day-by-day count would.
                if (days_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cal_cmd.step = 1'b1;
                    days_next    = days_reg - 1'b1;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.cur_second = sec_reg;
                    rsp_next.cur_minute = min_reg;
                    rsp_next.cur_hour   = hour_reg;
                    rsp_next.cur_day    = cal_date.day;
                    rsp_next.cur_month  = cal_date.month;
                    rsp_next.cur_year   = cal_date.year;
                    rsp_next.load_error = err_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= '0;
            days_reg      <= '0;
            err_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            days_reg      <= days_next;
            err_reg       <= err_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // The result word itself needs no reset; its valid bit does.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hdl/ccadv_check.sv @@
// ============================================================================
// ccadv_check: port checker for the calendar clock
// Watches the ports of the top level for handshake and range slips and is
// bound to every instance of it.
// ============================================================================
module ccadv_check (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_stall,
    input ccadv_pkg::cmd_word_t cmd,
    input logic                 rsp_valid,
    input logic                 rsp_stall,
    input ccadv_pkg::rsp_word_t rsp
);
    import ccadv_pkg::*;

    // A stalled result word stays valid.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its value.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("result word changed while stalled");

    // Once a command word is taken the block works on it and takes no other.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while the previous one is in progress");

    // Every reported time is a real time of day and a real date.
    a_rsp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.cur_second < 6'd60) && (rsp.cur_minute < 6'd60)
                   && (rsp.cur_hour < 5'd24) && (rsp.cur_day >= 5'd1)
                   && (rsp.cur_day <= days_in(rsp.cur_month, rsp.cur_year))
                   && (rsp.cur_month >= 4'd1) && (rsp.cur_month <= 4'd12))
        else $error("result word holds a time out of range");

endmodule

bind calendar_clock_advance_unit ccadv_check u_ccadv_check (.*);
